@@ rtl/jhgs_pkg.sv @@
// Shared constants and types of the Jacobi heat grid solver.
package jhgs_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int CELL_W          = 8 + FRAC_BITS;
    localparam int DIM_W           = 7;
    localparam int COUNT_OUT_W     = 21;
    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_MAX_COLS    = 64;
    localparam int DEF_SWEEP_LIMIT = 1048576;

    // Reset values of the configuration registers (temperatures in Q8.16).
    localparam logic [DIM_W-1:0]  RST_ROWS    = 7'd8;
    localparam logic [DIM_W-1:0]  RST_COLS    = 7'd8;
    localparam logic [CELL_W-1:0] RST_TOL     = 24'd7;
    localparam logic [CELL_W-1:0] RST_LEFT    = 24'd655360;
    localparam logic [CELL_W-1:0] RST_RIGHT   = 24'd9175040;
    localparam logic [CELL_W-1:0] RST_TOP     = 24'd1310720;
    localparam logic [CELL_W-1:0] RST_BOTTOM  = 24'd6553600;
    localparam logic [CELL_W-1:0] RST_INITIAL = 24'd1966080;

    typedef enum logic [2:0] {
        REG_ROWS    = 3'd0,
        REG_COLS    = 3'd1,
        REG_TOL     = 3'd2,
        REG_LEFT    = 3'd3,
        REG_RIGHT   = 3'd4,
        REG_TOP     = 3'd5,
        REG_BOTTOM  = 3'd6,
        REG_INITIAL = 3'd7
    } cfg_index_t;

endpackage

@@ rtl/jacobi_heat_grid_solver_top.sv @@
// Top level of the Jacobi heat grid solver: grid memories, sweep sequencer and stream ports.
//
// A read beat passes through the read and output states before its result beat is raised.
// A run beat fills the grid of m rows and n columns with its boundary and initial values,
// then sweeps it: each interior cell needs four single-port reads in the stencil pass and a
// read plus a write-back in the update pass, all through the one grid memory port. After
// reset a clearing pass over all (MAX_ROWS+2)*(MAX_COLS+2) entries (4356 by default)
// writes the reset temperature into the grid; no input beat is taken meanwhile.
// aresetn is synchronous and active low; configuration writes are taken in every state.
module jacobi_heat_grid_solver_top #(
    parameter int MAX_ROWS    = jhgs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS    = jhgs_pkg::DEF_MAX_COLS,
    parameter int SWEEP_LIMIT = jhgs_pkg::DEF_SWEEP_LIMIT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // Configuration write port.
    input  logic                     cfg_we,
    input  logic [2:0]               cfg_index,
    input  logic [jhgs_pkg::CELL_W-1:0] cfg_wdata,
    // Request stream.
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // s_tdata fields from bit 0: cell_row[6:0], cell_col[13:7], zero pad [15:14].
    input  logic [15:0]              s_tdata,
    // s_tuser fields from bit 0: mode (0 run, 1 read).
    input  logic                     s_tuser,
    // Result stream.
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // m_tdata fields from bit 0: sweep_count[20:0], max_change[44:21], converged[45],
    // cell_value[69:46], bad_coordinate[70], zero pad [71].
    output logic [71:0]              m_tdata
);
    import jhgs_pkg::*;

    localparam int STRIDE     = MAX_COLS + 2;
    localparam int GRID_DEPTH = (MAX_ROWS + 2) * (MAX_COLS + 2);
    localparam int NEXT_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int GRID_AW    = $clog2(GRID_DEPTH);
    localparam int NEXT_AW    = (NEXT_DEPTH > 1) ? $clog2(NEXT_DEPTH) : 1;
    localparam int ROW_W      = $clog2(MAX_ROWS + 2);
    localparam int COL_W      = $clog2(MAX_COLS + 2);
    localparam int SW_W       = $clog2(SWEEP_LIMIT + 1);
    localparam int SUM_W      = CELL_W + 2;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_INIT, S_SWEEP, S_COPY, S_READ, S_OUT
    } state_t;

    // Configuration registers.
    logic [DIM_W-1:0]  rows_reg, cols_reg;
    logic [CELL_W-1:0] tol_reg, left_reg, right_reg, top_reg, bottom_reg, initial_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg    <= RST_ROWS;
            cols_reg    <= RST_COLS;
            tol_reg     <= RST_TOL;
            left_reg    <= RST_LEFT;
            right_reg   <= RST_RIGHT;
            top_reg     <= RST_TOP;
            bottom_reg  <= RST_BOTTOM;
            initial_reg <= RST_INITIAL;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                REG_ROWS:    rows_reg    <= cfg_wdata[DIM_W-1:0];
                REG_COLS:    cols_reg    <= cfg_wdata[DIM_W-1:0];
                REG_TOL:     tol_reg     <= cfg_wdata;
                REG_LEFT:    left_reg    <= cfg_wdata;
                REG_RIGHT:   right_reg   <= cfg_wdata;
                REG_TOP:     top_reg     <= cfg_wdata;
                REG_BOTTOM:  bottom_reg  <= cfg_wdata;
                REG_INITIAL: initial_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Dimensions in use, saturated into 1..MAX.
    logic [ROW_W-1:0] m_clamp;
    logic [COL_W-1:0] n_clamp;
    always_comb begin
        if (rows_reg == '0) begin
            m_clamp = ROW_W'(1);
        end else if (int'(rows_reg) > MAX_ROWS) begin
            m_clamp = ROW_W'(MAX_ROWS);
        end else begin
            m_clamp = ROW_W'(rows_reg);
        end
        if (cols_reg == '0) begin
            n_clamp = COL_W'(1);
        end else if (int'(cols_reg) > MAX_COLS) begin
            n_clamp = COL_W'(MAX_COLS);
        end else begin
            n_clamp = COL_W'(cols_reg);
        end
    end

    // Sequencer registers.
    state_t            state_reg;
    logic [GRID_AW-1:0] clr_reg;
    logic [ROW_W-1:0]  m_reg, i_reg;
    logic [COL_W-1:0]  n_reg, j_reg;
    logic [2:0]        k_reg;
    logic              ph_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CELL_W-1:0] maxd_reg;
    logic [SW_W-1:0]   iter_reg;
    logic [SW_W-1:0]   sweeps_done_reg;
    logic [CELL_W-1:0] last_max_reg;
    logic              last_conv_reg;
    logic              pend_bad_reg;
    logic [CELL_W-1:0] pend_cell_reg;
    logic              m_tvalid_reg;
    logic [71:0]       m_tdata_reg;

    // Memories and their ports.
    logic [CELL_W-1:0] grid_mem [GRID_DEPTH];
    logic [CELL_W-1:0] next_mem [NEXT_DEPTH];
    logic              grid_we, next_we;
    logic [GRID_AW-1:0] grid_waddr, grid_raddr;
    logic [CELL_W-1:0] grid_wdata, grid_rdata_reg;
    logic [NEXT_AW-1:0] next_waddr, next_raddr;
    logic [CELL_W-1:0] next_wdata, next_rdata_reg;

    function automatic logic [GRID_AW-1:0] gaddr(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
        gaddr = GRID_AW'(int'(r) * STRIDE + int'(c));
    endfunction

    function automatic logic [NEXT_AW-1:0] naddr(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
        naddr = NEXT_AW'((int'(r) - 1) * MAX_COLS + (int'(c) - 1));
    endfunction

    always_ff @(posedge aclk) begin
        if (grid_we) begin
            grid_mem[grid_waddr] <= grid_wdata;
        end
        grid_rdata_reg <= grid_mem[grid_raddr];
    end

    always_ff @(posedge aclk) begin
        if (next_we) begin
            next_mem[next_waddr] <= next_wdata;
        end
        next_rdata_reg <= next_mem[next_raddr];
    end

    // Request decode.
    logic             in_fire;
    logic [DIM_W-1:0] req_row, req_col;
    logic             req_bad;
    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign req_row  = s_tdata[6:0];
    assign req_col  = s_tdata[13:7];
    assign req_bad  = (int'(req_row) > int'(m_clamp) + 1) || (int'(req_col) > int'(n_clamp) + 1);

    // Stencil and update arithmetic.
    logic              last_cell;
    logic [SUM_W-1:0]  sum_total;
    logic [CELL_W-1:0] diff, new_max;
    logic [SW_W-1:0]   iter_inc;
    logic              sweep_again;
    logic              init_row_in, init_col_in;
    logic [CELL_W-1:0] init_value;

    assign last_cell = (i_reg == m_reg) && (j_reg == n_reg);
    assign sum_total = sum_reg + SUM_W'(grid_rdata_reg);
    assign diff      = (next_rdata_reg > grid_rdata_reg) ? next_rdata_reg - grid_rdata_reg
                                                          : grid_rdata_reg - next_rdata_reg;
    assign new_max   = (diff > maxd_reg) ? diff : maxd_reg;
    assign iter_inc  = iter_reg + SW_W'(1);
    assign sweep_again = (new_max > tol_reg) && (int'(iter_inc) < SWEEP_LIMIT);

    // Boundary value during the fill pass; corners and interior take the initial value.
    assign init_row_in = (i_reg != '0) && (i_reg <= m_reg);
    assign init_col_in = (j_reg != '0) && (j_reg <= n_reg);
    always_comb begin
        if (init_row_in && j_reg == '0) begin
            init_value = left_reg;
        end else if (init_row_in && j_reg == n_reg + COL_W'(1)) begin
            init_value = right_reg;
        end else if (init_col_in && i_reg == '0) begin
            init_value = top_reg;
        end else if (init_col_in && i_reg == m_reg + ROW_W'(1)) begin
            init_value = bottom_reg;
        end else begin
            init_value = initial_reg;
        end
    end

    // Memory port control.
    always_comb begin
        grid_we    = 1'b0;
        grid_waddr = gaddr(i_reg, j_reg);
        grid_wdata = next_rdata_reg;
        grid_raddr = gaddr(i_reg, j_reg);
        next_we    = 1'b0;
        next_waddr = naddr(i_reg, j_reg);
        next_wdata = CELL_W'(sum_total >> 2);
        next_raddr = naddr(i_reg, j_reg);
        unique case (state_reg)
            S_CLEAR: begin
                grid_we    = 1'b1;
                grid_waddr = clr_reg;
                grid_wdata = RST_INITIAL;
            end
            S_IDLE: begin
                grid_raddr = gaddr(ROW_W'(req_row), COL_W'(req_col));
            end
            S_INIT: begin
                grid_we    = 1'b1;
                grid_wdata = init_value;
            end
            S_SWEEP: begin
                // Neighbors in order: above, below, left, right.
                case (k_reg)
                    3'd0:    grid_raddr = gaddr(i_reg - ROW_W'(1), j_reg);
                    3'd1:    grid_raddr = gaddr(i_reg + ROW_W'(1), j_reg);
                    3'd2:    grid_raddr = gaddr(i_reg, j_reg - COL_W'(1));
                    default: grid_raddr = gaddr(i_reg, j_reg + COL_W'(1));
                endcase
                next_we = (k_reg == 3'd4);
            end
            S_COPY: begin
                grid_we = ph_reg;
            end
            default: ;
        endcase
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            i_reg           <= '0;
            j_reg           <= '0;
            k_reg           <= '0;
            ph_reg          <= 1'b0;
            iter_reg        <= '0;
            maxd_reg        <= '0;
            sweeps_done_reg <= '0;
            last_max_reg    <= '0;
            last_conv_reg   <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            // The output state handles its own handshake below.
            if (m_tvalid_reg && m_tready && state_reg != S_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + GRID_AW'(1);
                    if (int'(clr_reg) == GRID_DEPTH - 1) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        m_reg <= m_clamp;
                        n_reg <= n_clamp;
                        i_reg <= '0;
                        j_reg <= '0;
                        pend_bad_reg  <= s_tuser && req_bad;
                        pend_cell_reg <= '0;
                        state_reg     <= s_tuser ? S_READ : S_INIT;
                    end
                end
                S_READ: begin
                    if (!pend_bad_reg) begin
                        pend_cell_reg <= grid_rdata_reg;
                    end
                    state_reg <= S_OUT;
                end
                S_INIT: begin
                    if (j_reg == n_reg + COL_W'(1)) begin
                        j_reg <= '0;
                        if (i_reg == m_reg + ROW_W'(1)) begin
                            i_reg     <= ROW_W'(1);
                            j_reg     <= COL_W'(1);
                            k_reg     <= '0;
                            iter_reg  <= '0;
                            state_reg <= S_SWEEP;
                        end else begin
                            i_reg <= i_reg + ROW_W'(1);
                        end
                    end else begin
                        j_reg <= j_reg + COL_W'(1);
                    end
                end
                S_SWEEP: begin
                    if (k_reg == 3'd1) begin
                        sum_reg <= SUM_W'(grid_rdata_reg);
                    end else if (k_reg != 3'd0) begin
                        sum_reg <= sum_total;
                    end
                    if (k_reg == 3'd4) begin
                        k_reg <= '0;
                        if (last_cell) begin
                            i_reg     <= ROW_W'(1);
                            j_reg     <= COL_W'(1);
                            ph_reg    <= 1'b0;
                            maxd_reg  <= '0;
                            state_reg <= S_COPY;
                        end else if (j_reg == n_reg) begin
                            j_reg <= COL_W'(1);
                            i_reg <= i_reg + ROW_W'(1);
                        end else begin
                            j_reg <= j_reg + COL_W'(1);
                        end
                    end else begin
                        k_reg <= k_reg + 3'd1;
                    end
                end
                S_COPY: begin
                    ph_reg <= !ph_reg;
                    if (ph_reg) begin
                        maxd_reg <= new_max;
                        if (last_cell) begin
                            i_reg    <= ROW_W'(1);
                            j_reg    <= COL_W'(1);
                            iter_reg <= iter_inc;
                            if (sweep_again) begin
                                k_reg     <= '0;
                                state_reg <= S_SWEEP;
                            end else begin
                                sweeps_done_reg <= iter_inc;
                                last_max_reg    <= new_max;
                                last_conv_reg   <= (new_max <= tol_reg);
                                state_reg       <= S_OUT;
                            end
                        end else if (j_reg == n_reg) begin
                            j_reg <= COL_W'(1);
                            i_reg <= i_reg + ROW_W'(1);
                        end else begin
                            j_reg <= j_reg + COL_W'(1);
                        end
                    end
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {1'b0, pend_bad_reg, pend_cell_reg, last_conv_reg,
                                         last_max_reg, COUNT_OUT_W'(sweeps_done_reg)};
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The grid is written only by the clearing, fill and update passes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        grid_we |-> (state_reg == S_CLEAR || state_reg == S_INIT || state_reg == S_COPY))
        else $error("grid written outside a writing pass");

    // The stencil pass never runs past its fifth step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SWEEP) |-> (k_reg <= 3'd4))
        else $error("stencil step counter out of range");

    // A result beat is only produced from the output state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == S_OUT))
        else $error("result beat raised outside the output state");

    // A run result never carries a read flag or cell value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SWEEP) |-> (!pend_bad_reg && pend_cell_reg == '0))
        else $error("run carries read fields");

endmodule
